@@ rtl/iqfir_pkg.sv @@
// Shared types and constants of the I/Q FIR filter with QPSK slicer.
package iqfir_pkg;

  localparam int TAP_COUNT  = 5;
  localparam int HELD_COUNT = TAP_COUNT - 1;
  localparam int TAG_W      = 31;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 8;
  localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W      = 26;
  localparam int QUOT_W     = 16;
  localparam int CFG_IDX_W  = 3;

  // Divide by 9 as multiply by ceil(2^29 / 9); exact for magnitudes below 2^27
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 26'd59652324;
  localparam int MULT_W      = SUM_W + RECIP_W;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 152;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [TAP_COUNT-1:0]    taps_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Power-on tap weights, newest tap in entry 0
  localparam taps_t TAP_RESET = {8'sd1, 8'sd2, 8'sd3, 8'sd2, 8'sd1};

  // Filter result of one rail
  typedef struct packed {
    logic signed [SUM_W-1:0]  sum;
    logic signed [QUOT_W-1:0] quot;
  } lane_res_t;

  // Fields that ride beside the filter pipeline
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    sample_t          raw_i;
    sample_t          raw_q;
    logic             fvalid;
  } side_t;

endpackage

@@ rtl/iqfir_lane.sv @@
// One rail of the filter: delay line, tap products, sum and divide by 9.
module iqfir_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                shift,
  input  iqfir_pkg::sample_t  sample,
  input  iqfir_pkg::taps_t    taps,
  output iqfir_pkg::lane_res_t res
);

  iqfir_pkg::sample_t hist [iqfir_pkg::HELD_COUNT];
  logic signed [iqfir_pkg::PROD_W-1:0] prod [iqfir_pkg::TAP_COUNT];
  logic signed [iqfir_pkg::SUM_W-1:0]  sum_s;
  logic signed [iqfir_pkg::SUM_W-1:0]  sum_next;
  logic signed [iqfir_pkg::SUM_W-1:0]  sum_a;
  logic        [iqfir_pkg::SUM_W-1:0]  mag_a;
  logic                                neg_a;
  logic signed [iqfir_pkg::SUM_W-1:0]  sum_m;
  logic        [iqfir_pkg::MULT_W-1:0] mult_m;
  logic                                neg_m;
  logic        [iqfir_pkg::QUOT_W-1:0] quot_mag;

  // Delay line, shifted on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < iqfir_pkg::HELD_COUNT; k++) hist[k] <= '0;
    end else if (shift) begin
      hist[0] <= sample;
      for (int k = 1; k < iqfir_pkg::HELD_COUNT; k++) hist[k] <= hist[k-1];
    end
  end

  // Tap products
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= iqfir_pkg::PROD_W'(sample * taps[0]);
      for (int k = 1; k < iqfir_pkg::TAP_COUNT; k++)
        prod[k] <= iqfir_pkg::PROD_W'(hist[k-1] * taps[k]);
    end
  end

  // Sum of products
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < iqfir_pkg::TAP_COUNT; k++)
      sum_next = sum_next + iqfir_pkg::SUM_W'(prod[k]);
  end

  // Sum, magnitude, reciprocal multiply
  always_ff @(posedge clk) begin
    if (en) begin
      sum_s  <= sum_next;
      sum_a  <= sum_s;
      neg_a  <= sum_s[iqfir_pkg::SUM_W-1];
      mag_a  <= sum_s[iqfir_pkg::SUM_W-1] ? iqfir_pkg::SUM_W'(-sum_s)
                                          : iqfir_pkg::SUM_W'(sum_s);
      sum_m  <= sum_a;
      neg_m  <= neg_a;
      mult_m <= iqfir_pkg::MULT_W'(mag_a) * iqfir_pkg::MULT_W'(iqfir_pkg::RECIP_MULT);
    end
  end

  // Quotient toward zero, low 16 bits kept
  assign quot_mag = mult_m[iqfir_pkg::RECIP_SHIFT +: iqfir_pkg::QUOT_W];
  assign res.sum  = sum_m;
  assign res.quot = neg_m ? iqfir_pkg::QUOT_W'(-quot_mag) : quot_mag;

endmodule

@@ rtl/iqfir_slicer.sv @@
// Merge stage: joins both rails, applies the valid mask, makes the hard bits.
module iqfir_slicer (
  input  logic                 clk,
  input  logic                 load,
  input  iqfir_pkg::lane_res_t res_i,
  input  iqfir_pkg::lane_res_t res_q,
  input  iqfir_pkg::side_t     side,
  output iqfir_pkg::side_t     side_out,
  output logic signed [iqfir_pkg::SUM_W-1:0]  sum_i,
  output logic signed [iqfir_pkg::SUM_W-1:0]  sum_q,
  output logic signed [iqfir_pkg::QUOT_W-1:0] filtered_i,
  output logic signed [iqfir_pkg::QUOT_W-1:0] filtered_q,
  output logic                 symbol_msb,
  output logic                 symbol_lsb
);

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      side_out <= side;
      sum_i    <= res_i.sum;
      sum_q    <= res_q.sum;
      if (side.fvalid) begin
        filtered_i <= res_i.quot;
        filtered_q <= res_q.quot;
        symbol_msb <= res_q.quot[iqfir_pkg::QUOT_W-1];
        symbol_lsb <= res_i.quot[iqfir_pkg::QUOT_W-1];
      end else begin
        filtered_i <= '0;
        filtered_q <= '0;
        symbol_msb <= 1'b0;
        symbol_lsb <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/iq_fir_qpsk_slicer.sv @@
// Top level: five-tap I/Q FIR filter, divide by 9 and QPSK hard decision.
//
//  channel | signals                          | direction | contents
//  --------+----------------------------------+-----------+---------------------------
//  s_axis  | s_tvalid s_tready s_tdata[63:0]  | in        | tag, in_phase, quadrature
//  m_axis  | m_tvalid m_tready m_tdata m_tuser| out       | filter result, tuser=valid
//  cfg     | cfg_valid cfg_ready cfg_index/data| in       | tap weight 0..4
//
// One request per clock while no result waits at the output; each result passes through
// the products, sum, magnitude, reciprocal multiply and output register in turn.
// The whole pipeline stalls while the output register holds an untaken result.
// Synchronous reset clears the delay lines, fill count and valid bits and loads
// the default weights.
module iq_fir_qpsk_slicer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [30:0] sample_tag, [46:31] in_phase, [62:47] quadrature, [63] zero
  input  logic [iqfir_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [30:0] tag_out, [46:31] raw_i, [62:47] raw_q, [88:63] sum_i,
  // [114:89] sum_q, [130:115] filtered_i, [146:131] filtered_q,
  // [147] symbol_msb, [148] symbol_lsb, [151:149] zero
  output logic [iqfir_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // [0] filter_valid
  output logic                                 m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iqfir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iqfir_pkg::WEIGHT_W-1:0]       cfg_data
);

  localparam int DEPTH = 4;

  iqfir_pkg::taps_t     taps;
  logic [2:0]           fill_count;
  logic                 en;
  logic                 accept;
  logic [DEPTH-1:0]     stage_valid;
  iqfir_pkg::side_t     side_p [DEPTH];
  iqfir_pkg::side_t     side_out;
  iqfir_pkg::lane_res_t res_i;
  iqfir_pkg::lane_res_t res_q;
  iqfir_pkg::sample_t   in_i;
  iqfir_pkg::sample_t   in_q;
  logic signed [iqfir_pkg::SUM_W-1:0]  sum_i;
  logic signed [iqfir_pkg::SUM_W-1:0]  sum_q;
  logic signed [iqfir_pkg::QUOT_W-1:0] filtered_i;
  logic signed [iqfir_pkg::QUOT_W-1:0] filtered_q;
  logic                 symbol_msb;
  logic                 symbol_lsb;

  assign in_i     = s_tdata[iqfir_pkg::TAG_W +: iqfir_pkg::SAMPLE_W];
  assign in_q     = s_tdata[iqfir_pkg::TAG_W + iqfir_pkg::SAMPLE_W +: iqfir_pkg::SAMPLE_W];

  // Pipeline advances unless a result waits at the output
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign accept    = s_tvalid && en;
  assign cfg_ready = 1'b1;

  // Tap weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= iqfir_pkg::TAP_RESET;
    end else if (cfg_valid && cfg_index < iqfir_pkg::CFG_IDX_W'(iqfir_pkg::TAP_COUNT)) begin
      taps[cfg_index] <= cfg_data;
    end
  end

  // Fill count, saturating once the delay line is full
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept && fill_count < 3'(iqfir_pkg::HELD_COUNT)) begin
      fill_count <= fill_count + 3'd1;
    end
  end

  // Stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      m_tvalid    <= 1'b0;
    end else if (en) begin
      stage_valid <= {stage_valid[DEPTH-2:0], accept};
      m_tvalid    <= stage_valid[DEPTH-1];
    end
  end

  // Side fields travel beside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      side_p[0].tag    <= s_tdata[iqfir_pkg::TAG_W-1:0];
      side_p[0].raw_i  <= in_i;
      side_p[0].raw_q  <= in_q;
      side_p[0].fvalid <= fill_count >= 3'(iqfir_pkg::HELD_COUNT);
      for (int k = 1; k < DEPTH; k++) side_p[k] <= side_p[k-1];
    end
  end

  iqfir_lane u_lane_i (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .shift  (accept),
    .sample (in_i),
    .taps   (taps),
    .res    (res_i)
  );

  iqfir_lane u_lane_q (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .shift  (accept),
    .sample (in_q),
    .taps   (taps),
    .res    (res_q)
  );

  iqfir_slicer u_slicer (
    .clk        (clk),
    .load       (en && stage_valid[DEPTH-1]),
    .res_i      (res_i),
    .res_q      (res_q),
    .side       (side_p[DEPTH-1]),
    .side_out   (side_out),
    .sum_i      (sum_i),
    .sum_q      (sum_q),
    .filtered_i (filtered_i),
    .filtered_q (filtered_q),
    .symbol_msb (symbol_msb),
    .symbol_lsb (symbol_lsb)
  );

  // Result packing
  assign m_tdata = {3'b000, symbol_lsb, symbol_msb, filtered_q, filtered_i,
                    sum_q, sum_i, side_out.raw_q, side_out.raw_i, side_out.tag};
  assign m_tuser = side_out.fvalid;

endmodule

@@ verif/iq_fir_qpsk_slicer_tb.sv @@
// Self-checking testbench for the I/Q FIR filter with QPSK hard decision.
`timescale 1ns / 1ps

module iq_fir_qpsk_slicer_tb;

  localparam int PIPE_LATENCY     = 5;
  localparam int HOLD_CYCLES      = 80;
  localparam int MAX_REPORTS      = 10;
  localparam int PHASE_COUNT      = 8;
  localparam int RANDOM_PER_PHASE = 166;

  // One filter result, split into its fields
  typedef struct {
    logic [iqfir_pkg::TAG_W-1:0]         tag;
    logic signed [15:0]                  raw_i;
    logic signed [15:0]                  raw_q;
    logic                                valid;
    logic signed [iqfir_pkg::SUM_W-1:0]  sum_i;
    logic signed [iqfir_pkg::SUM_W-1:0]  sum_q;
    logic signed [iqfir_pkg::QUOT_W-1:0] filt_i;
    logic signed [iqfir_pkg::QUOT_W-1:0] filt_q;
    logic                                msb;
    logic                                lsb;
  } fir_result_t;

  // Tracks tap weights and delay lines, predicts and checks filter results
  class fir_scoreboard;
    iqfir_pkg::weight_t taps [iqfir_pkg::TAP_COUNT];
    iqfir_pkg::sample_t hist_i [iqfir_pkg::HELD_COUNT];
    iqfir_pkg::sample_t hist_q [iqfir_pkg::HELD_COUNT];
    int unsigned        fill;
    fir_result_t        expected_q [$];
    int unsigned        errors;

    function new();
      foreach (taps[k]) taps[k] = iqfir_pkg::TAP_RESET[k];
      foreach (hist_i[k]) begin
        hist_i[k] = '0;
        hist_q[k] = '0;
      end
      fill   = 0;
      errors = 0;
    endfunction

    // Indexes past the last tap are dropped
    function void write_tap(logic [iqfir_pkg::CFG_IDX_W-1:0] idx,
                            logic [iqfir_pkg::WEIGHT_W-1:0] val);
      if (idx < iqfir_pkg::TAP_COUNT) taps[idx] = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Accepted request: form both rail sums and queue the expected result
    function void note_sample(logic [iqfir_pkg::IN_TDATA_W-1:0] d);
      fir_result_t        r;
      iqfir_pkg::sample_t xi;
      iqfir_pkg::sample_t xq;
      longint             si;
      longint             sq;
      longint             qi;
      longint             qq;
      xi = d[46:31];
      xq = d[62:47];
      si = longint'(xi) * longint'(taps[0]);
      sq = longint'(xq) * longint'(taps[0]);
      for (int k = 0; k < iqfir_pkg::HELD_COUNT; k++) begin
        si += longint'(hist_i[k]) * longint'(taps[k+1]);
        sq += longint'(hist_q[k]) * longint'(taps[k+1]);
      end
      // signed division truncates toward zero
      qi = si / 9;
      qq = sq / 9;
      r.tag    = d[30:0];
      r.raw_i  = xi;
      r.raw_q  = xq;
      r.valid  = (fill >= iqfir_pkg::HELD_COUNT);
      r.sum_i  = si[iqfir_pkg::SUM_W-1:0];
      r.sum_q  = sq[iqfir_pkg::SUM_W-1:0];
      r.filt_i = r.valid ? qi[iqfir_pkg::QUOT_W-1:0] : '0;
      r.filt_q = r.valid ? qq[iqfir_pkg::QUOT_W-1:0] : '0;
      r.msb    = r.valid & r.filt_q[iqfir_pkg::QUOT_W-1];
      r.lsb    = r.valid & r.filt_i[iqfir_pkg::QUOT_W-1];
      expected_q.insert(expected_q.size(), r);
      // shift delay lines, newest in entry 0
      for (int k = iqfir_pkg::HELD_COUNT - 1; k > 0; k--) begin
        hist_i[k] = hist_i[k-1];
        hist_q[k] = hist_q[k-1];
      end
      hist_i[0] = xi;
      hist_q[0] = xq;
      if (fill < iqfir_pkg::HELD_COUNT) fill++;
    endfunction

    // Accepted result: compare against the oldest expectation
    function void check_result(logic [iqfir_pkg::OUT_TDATA_W-1:0] d, logic user);
      fir_result_t got;
      fir_result_t want;
      got.tag    = d[30:0];
      got.raw_i  = d[46:31];
      got.raw_q  = d[62:47];
      got.valid  = user;
      got.sum_i  = d[88:63];
      got.sum_q  = d[114:89];
      got.filt_i = d[130:115];
      got.filt_q = d[146:131];
      got.msb    = d[147];
      got.lsb    = d[148];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request pending, tag=%h", $realtime, got.tag);
        return;
      end
      want = expected_q.pop_front();
      if (got.tag !== want.tag || got.raw_i !== want.raw_i || got.raw_q !== want.raw_q ||
          got.valid !== want.valid || got.sum_i !== want.sum_i ||
          got.sum_q !== want.sum_q || got.filt_i !== want.filt_i ||
          got.filt_q !== want.filt_q || got.msb !== want.msb || got.lsb !== want.lsb) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch exp tag=%h raw=%0d/%0d v=%b sum=%0d/%0d filt=%0d/%0d sym=%b%b",
                   $realtime, want.tag, want.raw_i, want.raw_q, want.valid, want.sum_i,
                   want.sum_q, want.filt_i, want.filt_q, want.msb, want.lsb);
          $display("          act tag=%h raw=%0d/%0d v=%b sum=%0d/%0d filt=%0d/%0d sym=%b%b",
                   got.tag, got.raw_i, got.raw_q, got.valid, got.sum_i,
                   got.sum_q, got.filt_i, got.filt_q, got.msb, got.lsb);
        end
      end
    endfunction

    // Anything still queued at the end never came out
    function void finish_check();
      if (expected_q.size() != 0) begin
        $display("%0d expected results never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              s_tvalid  = 1'b0;
  logic                              s_tready;
  logic [iqfir_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                              m_tvalid;
  logic                              m_tready  = 1'b0;
  logic [iqfir_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                              m_tuser;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [iqfir_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [iqfir_pkg::WEIGHT_W-1:0]    cfg_data  = '0;

  fir_scoreboard sb;
  bit            calm      = 1'b0;
  bit            hold_req  = 1'b0;
  int            hold_left = 0;

  iq_fir_qpsk_slicer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Random idle decision for either side, off during the calm stretch
  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 18);
  endfunction

  // Mostly full-range samples, with extremes and small values mixed in
  function automatic iqfir_pkg::sample_t pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return iqfir_pkg::sample_t'($urandom_range(40)) - 16'sd20;
      default: return iqfir_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !take_gap();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Offer one sample request and wait for it to be taken
  task automatic send_sample(input logic [iqfir_pkg::TAG_W-1:0] tag,
                             input iqfir_pkg::sample_t xi,
                             input iqfir_pkg::sample_t xq);
    while (take_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, xq, xi, tag};
    do @(posedge clk); while (!s_tready);
    sb.note_sample({1'b0, xq, xi, tag});
  endtask

  // Stop sending and let every outstanding result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [iqfir_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iqfir_pkg::WEIGHT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_tap(idx, val);
    @(posedge clk);
  endtask

  task automatic load_taps(input iqfir_pkg::weight_t w0, input iqfir_pkg::weight_t w1,
                           input iqfir_pkg::weight_t w2, input iqfir_pkg::weight_t w3,
                           input iqfir_pkg::weight_t w4);
    settle();
    write_reg(3'd0, w0);
    write_reg(3'd1, w1);
    write_reg(3'd2, w2);
    write_reg(3'd3, w3);
    write_reg(3'd4, w4);
  endtask

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    iqfir_pkg::weight_t w [iqfir_pkg::TAP_COUNT];
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset weights: extremes of tag and samples, valid turns on at the fifth
    send_sample(31'h0000_0000, 16'sh0000, 16'sh0000);
    send_sample(31'h7fff_ffff, 16'sh7fff, 16'sh7fff);
    send_sample(31'h2aaa_aaaa, 16'sh8000, 16'sh8000);
    send_sample(31'h5555_5555, 16'sh8000, 16'sh8000);
    send_sample(31'h0000_0004, 16'sh7fff, 16'sh8000);
    send_sample(31'h0000_0005, -16'sd1, 16'sd1);
    send_sample(31'h0000_0006, 16'sd1, -16'sd1);
    send_sample(31'h0000_0007, 16'sh0000, 16'sh0000);

    // Largest weights: quotient wider than 16 bits wraps
    load_taps(8'sh7f, 8'sh7f, 8'sh7f, 8'sh7f, 8'sh7f);
    repeat (5) send_sample(31'($urandom), 16'sh7fff, 16'sh8000);

    // Most negative weights on most negative samples: largest positive sum
    load_taps(8'sh80, 8'sh80, 8'sh80, 8'sh80, 8'sh80);
    repeat (5) send_sample(31'($urandom), 16'sh8000, 16'sh7fff);

    // Single tap: truncation toward zero and zero as a positive decision
    load_taps(8'sh01, 8'sh00, 8'sh00, 8'sh00, 8'sh00);
    send_sample(31'($urandom), -16'sd8, 16'sd8);
    send_sample(31'($urandom), -16'sd9, 16'sd9);
    send_sample(31'($urandom), 16'sd0, 16'sd0);
    send_sample(31'($urandom), 16'sd17, -16'sd17);

    // Random phases, each with its own weight setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      for (int k = 0; k < iqfir_pkg::TAP_COUNT; k++) begin
        case (p)
          1:       w[k] = 8'sh7f;
          2:       w[k] = 8'sh80;
          3:       w[k] = k[0] ? 8'sh80 : 8'sh7f;
          4:       w[k] = (k == 2) ? 8'sh7f : 8'sh00;
          default: w[k] = iqfir_pkg::weight_t'($urandom);
        endcase
      end
      load_taps(w[0], w[1], w[2], w[3], w[4]);
      // writes past the last tap must leave the weights alone
      if (p == 4) begin
        for (int k = iqfir_pkg::TAP_COUNT; k < 8; k++) write_reg(3'(k), 8'($urandom));
      end
      calm = (p == 1);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 3 && n == 40) hold_req = 1'b1;
        if (p == 5 && n == 80) settle();
        send_sample(31'($urandom), pick_sample(), pick_sample());
      end
    end
    calm = 1'b0;

    // Drain, then give the pipeline time to show any stray result
    s_tvalid <= 1'b0;
    for (int n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
